// ===== sv/multi_channel_deadline_timer_bank_core_defines.svh =====
// assertion macros shared by the timer bank rtl
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_BANK_CORE_DEFINES_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_BANK_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define MCDTB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCDTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mcdtb_pkg.sv =====
// types and constants of the deadline timer bank
package mcdtb_pkg;

   localparam int OP_W   = 2;
   localparam int ID_W   = 4;
   localparam int MS_W   = 16;
   localparam int TPM_W  = 16;
   localparam int CNT_W  = 32;
   localparam int MASK_W = 16;

   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_START   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
   localparam logic [OP_W-1:0] OP_STOP    = 2'd3;

   localparam logic [TPM_W-1:0] TPM_RESET = 16'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_MUL,
      ST_WRITE,
      ST_SEL_RD,
      ST_RESP
   } state_type;

endpackage

// ===== sv/mcdtb_ram.sv =====
// generic single write port ram with registered read
module mcdtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/multi_channel_deadline_timer_bank_core.sv =====
// bank of deadline timers: tick, start, restart and stop commands
//
// command channel: req_op, req_timer_id and req_deadline_ms are taken at a
// rising edge with start high and busy low. each command gives one response
// beat: rsp_valid is high for exactly one cycle with the expired and running
// masks and the count of the addressed timer. the receiver cannot stall it.
// csr_wr_en / csr_wr_data write ticks_per_ms at any edge, no wait states.
//
// states from the accepting edge to the response cycle:
//   tick            ST_WALK (one timer per cycle through the shared
//                   increment/compare unit, count and deadline rams), ST_SEL_RD
//   start           ST_MUL (one registered 16x16 multiply), ST_WRITE, ST_SEL_RD
//   restart, stop   ST_WRITE, ST_SEL_RD
// busy drops in the cycle after the response, so a new command is accepted
// only once the previous one has finished.
//
// reset stops all timers, clears both masks, marks every count as zero and
// sets ticks_per_ms to 1; commands may follow at the next edge.
`include "multi_channel_deadline_timer_bank_core_defines.svh"

module multi_channel_deadline_timer_bank_core #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [mcdtb_pkg::OP_W-1:0]   req_op,
   input  logic [mcdtb_pkg::ID_W-1:0]   req_timer_id,
   input  logic [mcdtb_pkg::MS_W-1:0]   req_deadline_ms,
   output logic                         rsp_valid,
   output logic [mcdtb_pkg::MASK_W-1:0] rsp_expired_mask,
   output logic [mcdtb_pkg::MASK_W-1:0] rsp_running_mask,
   output logic [mcdtb_pkg::CNT_W-1:0]  rsp_selected_count,
   input  logic                         csr_wr_en,
   input  logic [mcdtb_pkg::TPM_W-1:0]  csr_wr_data
);

   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int WC = $clog2(NUM_TIMERS + 1);
   localparam int MW = (NUM_TIMERS < mcdtb_pkg::MASK_W) ? NUM_TIMERS : mcdtb_pkg::MASK_W;
   localparam logic [WC-1:0] WALK_END = WC'(NUM_TIMERS);
   localparam int CW = mcdtb_pkg::CNT_W;

   mcdtb_pkg::state_type state_ff, state_in;

   logic [mcdtb_pkg::OP_W-1:0]  op_ff, op_in;
   logic [mcdtb_pkg::ID_W-1:0]  id_ff, id_in;
   logic [mcdtb_pkg::MS_W-1:0]  ms_ff, ms_in;
   logic                        id_ok_ff, id_ok_in;
   logic [CW-1:0]               prod_ff, prod_in;
   logic [mcdtb_pkg::TPM_W-1:0] tpm_ff, tpm_in;
   logic [WC-1:0]               walk_ff, walk_in;
   logic                        wb_vld_ff, wb_vld_in;
   logic [AW-1:0]               wb_idx_ff, wb_idx_in;
   logic [NUM_TIMERS-1:0]       running_ff, running_in;
   logic [NUM_TIMERS-1:0]       expired_ff, expired_in;
   logic [NUM_TIMERS-1:0]       cnt_vld_ff, cnt_vld_in;

   logic [AW-1:0] id_addr;
   logic          cnt_we, dl_we;
   logic [AW-1:0] cnt_waddr, cnt_raddr, dl_raddr;
   logic [CW-1:0] cnt_wdata, dl_wdata, cnt_rdata, dl_rdata;
   logic [CW-1:0] cur_cnt;
   logic [CW:0]   nxt_cnt;

   assign id_addr = AW'(id_ff);

   mcdtb_ram #(.WIDTH(CW), .DEPTH(NUM_TIMERS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   mcdtb_ram #(.WIDTH(CW), .DEPTH(NUM_TIMERS)) u_dl_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (id_addr),
      .wr_data (dl_wdata),
      .rd_addr (dl_raddr),
      .rd_data (dl_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcdtb_pkg::ST_IDLE: begin
            if (start) begin
               case (req_op)
                  mcdtb_pkg::OP_TICK:  state_in = mcdtb_pkg::ST_WALK;
                  mcdtb_pkg::OP_START: state_in = mcdtb_pkg::ST_MUL;
                  default:             state_in = mcdtb_pkg::ST_WRITE;
               endcase
            end
         end
         mcdtb_pkg::ST_WALK: begin
            if (walk_ff == WALK_END) begin
               state_in = mcdtb_pkg::ST_SEL_RD;
            end
         end
         mcdtb_pkg::ST_MUL:    state_in = mcdtb_pkg::ST_WRITE;
         mcdtb_pkg::ST_WRITE:  state_in = mcdtb_pkg::ST_SEL_RD;
         mcdtb_pkg::ST_SEL_RD: state_in = mcdtb_pkg::ST_RESP;
         mcdtb_pkg::ST_RESP:   state_in = mcdtb_pkg::ST_IDLE;
         default:              state_in = mcdtb_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      op_in      = op_ff;
      id_in      = id_ff;
      ms_in      = ms_ff;
      id_ok_in   = id_ok_ff;
      prod_in    = prod_ff;
      tpm_in     = csr_wr_en ? csr_wr_data : tpm_ff;
      walk_in    = walk_ff;
      wb_vld_in  = 1'b0;
      wb_idx_in  = wb_idx_ff;
      running_in = running_ff;
      expired_in = expired_ff;
      cnt_vld_in = cnt_vld_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = id_addr;
      cnt_wdata  = '0;
      cnt_raddr  = id_addr;
      dl_we      = 1'b0;
      dl_wdata   = '0;
      dl_raddr   = walk_ff[AW-1:0];
      cur_cnt    = cnt_vld_ff[wb_idx_ff] ? cnt_rdata : '0;
      nxt_cnt    = {1'b0, cur_cnt} + 1'b1;
      case (state_ff)
         mcdtb_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               id_in    = req_timer_id;
               ms_in    = req_deadline_ms;
               id_ok_in = (32'(req_timer_id) < NUM_TIMERS);
               walk_in  = '0;
            end
         end
         mcdtb_pkg::ST_WALK: begin
            // read timer walk_ff while timer wb_idx_ff is written back
            if (walk_ff != WALK_END) begin
               cnt_raddr = walk_ff[AW-1:0];
               wb_vld_in = 1'b1;
               wb_idx_in = walk_ff[AW-1:0];
               walk_in   = WC'(walk_ff + 1'b1);
            end
            if (wb_vld_ff && running_ff[wb_idx_ff]) begin
               cnt_we                = 1'b1;
               cnt_waddr             = wb_idx_ff;
               cnt_vld_in[wb_idx_ff] = 1'b1;
               if (nxt_cnt >= {1'b0, dl_rdata}) begin
                  expired_in[wb_idx_ff] = 1'b1;
                  cnt_wdata             = dl_rdata;
               end else begin
                  expired_in[wb_idx_ff] = 1'b0;
                  cnt_wdata             = nxt_cnt[CW-1:0];
               end
            end
         end
         mcdtb_pkg::ST_MUL: begin
            prod_in = {16'b0, ms_ff} * {16'b0, tpm_ff};
         end
         mcdtb_pkg::ST_WRITE: begin
            if (id_ok_ff) begin
               cnt_we              = 1'b1;
               cnt_vld_in[id_addr] = 1'b1;
               expired_in[id_addr] = 1'b0;
               case (op_ff)
                  mcdtb_pkg::OP_START: begin
                     dl_we               = 1'b1;
                     dl_wdata            = prod_ff;
                     running_in[id_addr] = 1'b1;
                  end
                  mcdtb_pkg::OP_STOP: begin
                     dl_we               = 1'b1;
                     running_in[id_addr] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mcdtb_pkg::ST_IDLE;
         tpm_ff     <= mcdtb_pkg::TPM_RESET;
         walk_ff    <= '0;
         wb_vld_ff  <= 1'b0;
         running_ff <= '0;
         expired_ff <= '0;
         cnt_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         tpm_ff     <= tpm_in;
         walk_ff    <= walk_in;
         wb_vld_ff  <= wb_vld_in;
         running_ff <= running_in;
         expired_ff <= expired_in;
         cnt_vld_ff <= cnt_vld_in;
      end
      op_ff     <= op_in;
      id_ff     <= id_in;
      ms_ff     <= ms_in;
      id_ok_ff  <= id_ok_in;
      prod_ff   <= prod_in;
      wb_idx_ff <= wb_idx_in;
   end

   assign busy               = (state_ff != mcdtb_pkg::ST_IDLE);
   assign rsp_valid          = (state_ff == mcdtb_pkg::ST_RESP);
   assign rsp_expired_mask   = mcdtb_pkg::MASK_W'(expired_ff[MW-1:0]);
   assign rsp_running_mask   = mcdtb_pkg::MASK_W'(running_ff[MW-1:0]);
   assign rsp_selected_count = (id_ok_ff && cnt_vld_ff[id_addr]) ? cnt_rdata : '0;

   `MCDTB_ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_valid, busy, "response beat outside busy")
   `MCDTB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted command did not raise busy")
   `MCDTB_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response beat longer than one cycle")
   `MCDTB_ASSERT_SAME(a_expired_running, clock, reset, 1'b1, (expired_ff & ~running_ff) == '0, "expired timer is not running")

endmodule
